[hdl/mkl_pkg.sv]
`default_nettype none

package mkl_pkg;

  // Stream word widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // Operation codes carried in tuser
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_MOVED     = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_REJECTED  = 3'd5;

  localparam logic [7:0] LEAD_LO = 8'h81;
  localparam logic [7:0] LEAD_HI = 8'hFE;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5A;
  localparam logic [7:0] LOWER_A = 8'h61;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return 8'(c - UPPER_A + LOWER_A);
    end
    return c;
  endfunction

  function automatic logic is_lead(input logic [7:0] c);
    return (c >= LEAD_LO) && (c <= LEAD_HI);
  endfunction

endpackage

`default_nettype wire

[hdl/mru_key_list.sv]
`default_nettype none

// Most-recently-used list of byte-string keys. A key streams in one byte per
// word on s_axis; tuser selects push, remove or read, and the word with tlast
// set runs the command chosen by its own operation code. Key compare folds
// ASCII A-Z to lower case, while a two-byte GBK pair (lead byte 0x81-0xFE plus
// a following byte, on both sides) must match exactly. Push moves a hit to the
// front with the new spelling, or inserts at the front and drops the oldest
// entry when full; keys of KEY_BYTES bytes or more are rejected. Remove drops
// the first match. Read returns one stored byte and the entry length. Every
// command, and every read, answers with one word on m_axis; a non-final key
// byte and operation 3 answer nothing. Steps: a command is accepted, then
// its key length is checked, then for every stored entry it walks, it fetches
// the entry length and takes one compare step per byte or byte pair that
// compares equal plus a final step, since the compare steps through the entry
// text memory and the key buffer one position a cycle; the walk stops at the
// first hit. A decide step then settles the command; a push then copies the
// key into its slot at one byte a cycle and ends in a flush state. A read
// passes an issue state and a done state for the registered memory reads.
// Each result then waits in the output register until taken; no new word is
// accepted meanwhile. Reset needs no clearing pass.
module mru_key_list #(
  parameter int ENTRIES   = 8,
  parameter int KEY_BYTES = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // key_byte[7:0], entry_index[10:8], byte_offset[18:11], zero fill
  input  wire logic [mkl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation[1:0]
  input  wire logic [mkl_pkg::IN_USER_W-1:0]   s_axis_tuser,
  // key_last
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status[2:0], hit_position[5:3], entry_count[9:6], read_byte[17:10],
  // read_length[25:18], zero fill
  output logic [mkl_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  import mkl_pkg::*;

  localparam int LW  = $clog2(KEY_BYTES);
  localparam int KLW = $clog2(KEY_BYTES + 1);
  localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW  = $clog2(ENTRIES + 1);
  localparam int TAW = SW + LW;
  localparam int TEXT_DEPTH = ENTRIES * (2 ** LW);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_LEN, S_CMP, S_DECIDE, S_COPY, S_FLUSH,
    S_RD_ISSUE, S_RD_DONE, S_OUT
  } state_t;

  state_t state;

  // Storage
  logic [7:0]    key_mem  [KEY_BYTES];
  logic [7:0]    text_mem [TEXT_DEPTH];
  logic [LW-1:0] len_mem  [ENTRIES];
  logic [SW-1:0] order    [ENTRIES];
  logic [PW-1:0] total;
  logic [KLW-1:0] klen;

  // Command context
  logic          is_push;
  logic [2:0]    idx_q;
  logic [7:0]    off_q;
  logic [PW-1:0] p;
  logic [LW-1:0] i, j;
  logic          hit_found;
  logic [SW-1:0] hit_pos;
  logic [LW-1:0] c;
  logic [SW-1:0] cslot;
  logic          wr_pend;
  logic [TAW-1:0] wr_addr;

  // Registered memory read data
  logic [7:0]    ka_q, kb_q, ta_q, tb_q;
  logic [LW-1:0] len_q;

  // Output register
  logic          out_valid;
  logic [2:0]    out_status, out_hit;
  logic [3:0]    out_count;
  logic [7:0]    out_rbyte, out_rlen;

  // Input word fields
  logic [1:0] in_op;
  logic [7:0] in_byte, in_off;
  logic [2:0] in_idx;
  logic       in_acc;

  assign in_op   = s_axis_tuser[1:0];
  assign in_byte = s_axis_tdata[7:0];
  assign in_idx  = s_axis_tdata[10:8];
  assign in_off  = s_axis_tdata[18:11];
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_rlen, out_rbyte, out_count, out_hit, out_status};

  // Compare step
  logic [SW-1:0] cur_slot;
  logic [LW-1:0] lk;
  logic          at_end, full_match, pair, step_eq;
  logic [LW-1:0] ni, nj;

  assign cur_slot = order[p[SW-1:0]];
  assign lk       = klen[LW-1:0];

  always_comb begin
    at_end     = (i == len_q) || (j == lk);
    full_match = (i == len_q) && (j == lk);
    pair = is_lead(ta_q) && (({1'b0, i} + 1'b1) < {1'b0, len_q}) &&
           is_lead(ka_q) && (({1'b0, j} + 1'b1) < {1'b0, lk});
    step_eq = pair ? ((ta_q == ka_q) && (tb_q == kb_q))
                   : (fold_case(ta_q) == fold_case(ka_q));
    ni = pair ? LW'(i + 2'd2) : LW'(i + 1'b1);
    nj = pair ? LW'(j + 2'd2) : LW'(j + 1'b1);
  end

  // Memory addresses
  logic [LW-1:0]  key_addr_a, key_addr_b;
  logic [TAW-1:0] text_addr_a, text_addr_b;
  logic [SW-1:0]  len_addr, rd_slot;

  assign rd_slot = order[SW'(idx_q)];

  always_comb begin
    key_addr_a  = '0;
    key_addr_b  = '0;
    text_addr_a = '0;
    text_addr_b = '0;
    len_addr    = '0;
    unique case (state)
      S_LEN: begin
        key_addr_b  = LW'(1);
        text_addr_a = {cur_slot, LW'(0)};
        text_addr_b = {cur_slot, LW'(1)};
        len_addr    = cur_slot;
      end
      S_CMP: begin
        key_addr_a  = nj;
        key_addr_b  = LW'(nj + 1'b1);
        text_addr_a = {cur_slot, ni};
        text_addr_b = {cur_slot, LW'(ni + 1'b1)};
        len_addr    = cur_slot;
      end
      S_COPY: begin
        key_addr_a = c;
      end
      S_RD_ISSUE: begin
        text_addr_a = {rd_slot, LW'(off_q)};
        len_addr    = rd_slot;
      end
      default: begin
      end
    endcase
  end

  // Command decision
  logic [SW-1:0] target, dec_slot;
  logic [2:0]    push_status;
  logic          len_we;

  always_comb begin
    if (hit_found) begin
      target      = hit_pos;
      push_status = ST_MOVED;
    end else if (total < PW'(ENTRIES)) begin
      target      = total[SW-1:0];
      push_status = ST_INSERTED;
    end else begin
      target      = SW'(ENTRIES - 1);
      push_status = ST_EVICTED;
    end
    dec_slot = order[target];
    len_we   = (state == S_DECIDE) && is_push;
  end

  // Memories
  logic key_we;
  assign key_we = in_acc && (in_op != OP_READ) && (in_op != OP_NONE) &&
                  (klen < KLW'(KEY_BYTES));

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[klen[LW-1:0]] <= in_byte;
    end
    ka_q <= key_mem[key_addr_a];
    kb_q <= key_mem[key_addr_b];
  end

  always_ff @(posedge clk) begin
    if (wr_pend) begin
      text_mem[wr_addr] <= ka_q;
    end
    ta_q <= text_mem[text_addr_a];
    tb_q <= text_mem[text_addr_b];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[dec_slot] <= lk;
    end
    len_q <= len_mem[len_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      klen      <= '0;
      out_valid <= 1'b0;
      wr_pend   <= 1'b0;
      for (int q = 0; q < ENTRIES; q++) begin
        order[q] <= SW'(q);
      end
    end else begin
      wr_pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_op == OP_READ) begin
              idx_q <= in_idx;
              off_q <= in_off;
              state <= S_RD_ISSUE;
            end else if (in_op != OP_NONE) begin
              if (key_we) begin
                klen <= KLW'(klen + 1'b1);
              end
              if (s_axis_tlast) begin
                is_push <= (in_op == OP_PUSH);
                state   <= S_FIND;
              end
            end
          end
        end
        S_FIND: begin
          hit_found <= 1'b0;
          p         <= '0;
          if (klen >= KLW'(KEY_BYTES)) begin
            out_status <= is_push ? ST_REJECTED : ST_NOT_FOUND;
            out_hit    <= '0;
            out_count  <= 4'(total);
            out_rbyte  <= '0;
            out_rlen   <= '0;
            out_valid  <= 1'b1;
            klen       <= '0;
            state      <= S_OUT;
          end else if (total == '0) begin
            state <= S_DECIDE;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          i     <= '0;
          j     <= '0;
          state <= S_CMP;
        end
        S_CMP: begin
          if (at_end && full_match) begin
            hit_found <= 1'b1;
            hit_pos   <= p[SW-1:0];
            state     <= S_DECIDE;
          end else if (at_end || !step_eq) begin
            // move on to the next entry
            if (PW'(p + 1'b1) == total) begin
              state <= S_DECIDE;
            end else begin
              p     <= PW'(p + 1'b1);
              state <= S_LEN;
            end
          end else begin
            i <= ni;
            j <= nj;
          end
        end
        S_DECIDE: begin
          out_rbyte <= '0;
          out_rlen  <= '0;
          if (is_push) begin
            for (int q = 1; q < ENTRIES; q++) begin
              if (SW'(q) <= target) begin
                order[q] <= order[q-1];
              end
            end
            order[0] <= dec_slot;
            out_status <= push_status;
            out_hit    <= hit_found ? 3'(hit_pos) : 3'd0;
            if (!hit_found && total < PW'(ENTRIES)) begin
              total     <= PW'(total + 1'b1);
              out_count <= 4'(total + 1'b1);
            end else begin
              out_count <= 4'(total);
            end
            cslot <= dec_slot;
            c     <= '0;
            state <= S_COPY;
          end else begin
            if (hit_found) begin
              // close the gap and park the freed slot past the end
              for (int q = 0; q < ENTRIES; q++) begin
                if ((SW'(q) >= hit_pos) && (32'(q) + 1 < 32'(total))) begin
                  order[q] <= order[(q + 1) % ENTRIES];
                end
              end
              order[SW'(total - 1'b1)] <= order[hit_pos];
              total      <= PW'(total - 1'b1);
              out_count  <= 4'(total - 1'b1);
              out_status <= ST_REMOVED;
              out_hit    <= 3'(hit_pos);
            end else begin
              out_count  <= 4'(total);
              out_status <= ST_NOT_FOUND;
              out_hit    <= '0;
            end
            klen      <= '0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_COPY: begin
          wr_pend <= 1'b1;
          wr_addr <= {cslot, c};
          c       <= LW'(c + 1'b1);
          if (LW'(c + 1'b1) == lk) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          klen      <= '0;
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_RD_ISSUE: begin
          state <= S_RD_DONE;
        end
        S_RD_DONE: begin
          out_status <= '0;
          out_hit    <= '0;
          out_count  <= 4'(total);
          if (32'(idx_q) < 32'(total)) begin
            out_rlen  <= 8'(len_q);
            out_rbyte <= (32'(off_q) < 32'(len_q)) ? ta_q : 8'd0;
          end else begin
            out_rlen  <= '0;
            out_rbyte <= '0;
          end
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= PW'(ENTRIES))
    else $error("entry total beyond list size");

  a_klen_bound: assert property (@(posedge clk) disable iff (rst)
    klen <= KLW'(KEY_BYTES))
    else $error("key length beyond buffer size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");

  a_copy_ends_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> (klen == '0) && m_axis_tvalid)
    else $error("push did not finish with an empty key buffer");

endmodule

`default_nettype wire

[tb/tb_mru_key_list.sv]
`default_nettype none

module tb_mru_key_list;
  import mkl_pkg::*;

  localparam int SLOTS     = 8;
  localparam int KEY_MAX   = 256;
  // random words per idling phase; the long keys add about 790 more words
  localparam int PHASE_WORDS = 85;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0] op;
    logic [7:0] kb;
    logic       klast;
    logic [2:0] idx;
    logic [7:0] off;
    int         src_idle;   // percent chance the sender holds off before this word
    int         sink_stall; // percent chance the receiver stalls while this word is live
  } word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] hit;
    logic [3:0] count;
    logic [7:0] rbyte;
    logic [7:0] rlen;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = OP_NONE;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  mru_key_list #(.ENTRIES(SLOTS), .KEY_BYTES(KEY_MAX)) dut (.*);

  // Shadow copy of the list
  logic [7:0] key_buf [KEY_MAX];
  int         key_len;
  logic [7:0] slot_txt [SLOTS][KEY_MAX];
  int         slot_len [SLOTS];
  int         order [SLOTS];
  int         total;

  word_t   pending_words [$];
  answer_t expected_answers [$];
  word_t   cur_word;
  int      stall_pct = 0;
  int      mismatches = 0;
  int      answers_seen = 0;
  int      words_sent = 0;
  int      status_seen [8];
  int      reads_seen = 0;
  int      cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] lower(logic [7:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) return 8'(c - UPPER_A + LOWER_A);
    return c;
  endfunction

  function automatic bit gbk_lead(logic [7:0] c);
    return c >= LEAD_LO && c <= LEAD_HI;
  endfunction

  // Walk one stored entry against the buffered key; GBK pairs compare exactly
  function automatic bit slot_equal(int slot);
    int i = 0;
    int j = 0;
    logic [7:0] x, y;
    while (i < slot_len[slot] && j < key_len) begin
      x = slot_txt[slot][i];
      y = key_buf[j];
      if (gbk_lead(x) && i + 1 < slot_len[slot] && gbk_lead(y) && j + 1 < key_len) begin
        if (x != y || slot_txt[slot][i+1] != key_buf[j+1]) return 0;
        i += 2;
        j += 2;
      end else begin
        if (lower(x) != lower(y)) return 0;
        i++;
        j++;
      end
    end
    return i == slot_len[slot] && j == key_len;
  endfunction

  function automatic int find_position();
    if (key_len >= KEY_MAX) return -1;
    for (int p = 0; p < total; p++)
      if (slot_equal(order[p])) return p;
    return -1;
  endfunction

  // Advance the shadow list by one accepted word and queue its answer, if any
  task automatic predict_list(input word_t w);
    answer_t a;
    int hit, tgt, slot;
    a = '0;
    if (w.op == OP_READ) begin
      if (w.idx < total) begin
        slot = order[w.idx];
        if (w.off < slot_len[slot]) a.rbyte = slot_txt[slot][w.off];
        a.rlen = 8'(slot_len[slot]);
      end
      a.count = 4'(total);
      reads_seen++;
      expected_answers.push_back(a);
      return;
    end
    if (w.op == OP_NONE) return;
    if (key_len < KEY_MAX) begin
      key_buf[key_len] = w.kb;
      key_len++;
    end
    if (!w.klast) return;
    if (w.op == OP_PUSH) begin
      if (key_len >= KEY_MAX) begin
        a.status = ST_REJECTED;
      end else begin
        hit = find_position();
        if (hit >= 0) begin
          tgt = hit;
          a.status = ST_MOVED;
          a.hit = 3'(hit);
        end else if (total < SLOTS) begin
          tgt = total;
          total++;
          a.status = ST_INSERTED;
        end else begin
          tgt = SLOTS - 1;
          a.status = ST_EVICTED;
        end
        slot = order[tgt];
        for (int p = tgt; p > 0; p--) order[p] = order[p-1];
        order[0] = slot;
        for (int k = 0; k < key_len; k++) slot_txt[slot][k] = key_buf[k];
        slot_len[slot] = key_len;
      end
    end else begin
      hit = find_position();
      if (hit < 0) begin
        a.status = ST_NOT_FOUND;
      end else begin
        slot = order[hit];
        for (int p = hit; p + 1 < total; p++) order[p] = order[p+1];
        order[total-1] = slot;
        total--;
        a.status = ST_REMOVED;
        a.hit = 3'(hit);
      end
    end
    a.count = 4'(total);
    key_len = 0;
    expected_answers.push_back(a);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  int src_idle_now = 0;
  int sink_stall_now = 0;

  task automatic add_word(input logic [1:0] op, input logic [7:0] kb, input logic klast,
                          input logic [2:0] idx, input logic [7:0] off);
    word_t w;
    w.op = op;
    w.kb = kb;
    w.klast = klast;
    w.idx = idx;
    w.off = off;
    w.src_idle = src_idle_now;
    w.sink_stall = sink_stall_now;
    pending_words.push_back(w);
  endtask

  task automatic add_read(input logic [2:0] idx, input logic [7:0] off);
    add_word(OP_READ, 8'($urandom), 1'($urandom), idx, off);
  endtask

  // Send a key; earlier bytes carry a random push/remove code, the last one the command.
  // With noise set, reads and unused words are slipped in between key bytes.
  task automatic send_key(input logic [7:0] k [$], input logic [1:0] op, input bit noise);
    logic [1:0] early;
    for (int i = 0; i < k.size(); i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        add_read(3'($urandom), 8'($urandom_range(0, 7)));
      if (noise && $urandom_range(0, 19) == 0)
        add_word(OP_NONE, 8'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
      early = $urandom_range(0, 1) ? OP_PUSH : OP_REMOVE;
      add_word(i == k.size() - 1 ? op : early, k[i], i == k.size() - 1,
               3'($urandom), 8'($urandom));
    end
  endtask

  logic [7:0] pool [12][$];

  // Pick a pool key and scramble letter case; sometimes a fresh random key
  task automatic make_key(output logic [7:0] k [$]);
    int n;
    k = {};
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) k.push_back(8'($urandom_range(1, 255)));
      return;
    end
    k = pool[$urandom_range(0, 11)];
    foreach (k[i]) begin
      if (lower(k[i]) >= LOWER_A && lower(k[i]) <= LOWER_A + 25 && $urandom_range(0, 1))
        k[i] = k[i] ^ 8'h20;
    end
  endtask

  task automatic build_stimulus();
    logic [7:0] k [$];
    int phase;
    int start;
    pool[0]  = '{8'h61};
    pool[1]  = '{8'h41, 8'h62};
    pool[2]  = '{8'h63, 8'h61, 8'h74};
    pool[3]  = '{8'h81, 8'h41};
    pool[4]  = '{8'h81, 8'h61};
    pool[5]  = '{8'h61, 8'hFE};
    pool[6]  = '{8'hB0, 8'hA1, 8'h78};
    pool[7]  = '{8'hFF, 8'h80, 8'h01};
    pool[8]  = '{8'h5A, 8'h7A, 8'h40, 8'h5B};
    pool[9]  = '{8'h81, 8'h81, 8'hFE};
    pool[10] = '{8'h64, 8'h6F, 8'h67, 8'h73, 8'h21};
    pool[11] = '{8'h7F};

    // Directed: insert, move with new spelling, GBK pair compared exactly
    send_key(pool[2], OP_PUSH, 0);
    send_key('{8'h43, 8'h41, 8'h54}, OP_PUSH, 0);    // folds onto "cat", moves to front
    send_key(pool[3], OP_PUSH, 0);
    send_key(pool[4], OP_PUSH, 0);                    // GBK pair differs: new entry
    send_key('{8'h61, 8'h81}, OP_REMOVE, 0);          // lead on final byte: not found
    add_read(3'd0, 8'd0);
    add_read(3'd1, 8'd1);
    add_read(3'd2, 8'd255);                           // beyond entry length
    add_read(3'd7, 8'd0);                             // empty position
    add_word(OP_NONE, 8'hFF, 1'b1, 3'd7, 8'hFF);      // ignored
    send_key(pool[4], OP_REMOVE, 0);
    send_key('{8'hFF}, OP_PUSH, 0);
    send_key('{8'h01}, OP_PUSH, 0);
    // Partly loaded key survives a read
    add_word(OP_REMOVE, 8'h63, 1'b0, 3'd0, 8'd0);
    add_read(3'd0, 8'd0);
    add_word(OP_PUSH, 8'h61, 1'b0, 3'd0, 8'd0);
    add_word(OP_PUSH, 8'h74, 1'b1, 3'd0, 8'd0);

    // Random part: four idling phases, twice through
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin src_idle_now = 0;  sink_stall_now = 0;  end
        1: begin src_idle_now = 56; sink_stall_now = 0;  end
        2: begin src_idle_now = 0;  sink_stall_now = 56; end
        default: begin src_idle_now = 23; sink_stall_now = 23; end
      endcase
      start = pending_words.size();
      while (pending_words.size() < start + PHASE_WORDS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin make_key(k); send_key(k, OP_PUSH, 1); end
          5, 6: begin make_key(k); send_key(k, OP_REMOVE, 1); end
          default: add_read(3'($urandom), $urandom_range(0, 3) == 0 ?
                            8'($urandom) : 8'($urandom_range(0, 6)));
        endcase
      end
      // A few long keys: one just fits, the rest overflow the buffer
      if (phase == 3) begin
        k = {};
        repeat (255) k.push_back(8'($urandom_range(1, 255)));
        send_key(k, OP_PUSH, 0);
        add_read(3'd0, 8'd254);
        add_read(3'd0, 8'($urandom));
        k.push_back(8'($urandom_range(1, 255)));
        send_key(k, OP_PUSH, 0);
        repeat (20) k.push_back(8'($urandom_range(1, 255)));
        send_key(k, $urandom_range(0, 1) ? OP_PUSH : OP_REMOVE, 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: hold the word until taken, then advance
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_list(cur_word);
        words_sent++;
      end
      if (pending_words.size() > 0 &&
          $urandom_range(0, 99) >= pending_words[0].src_idle) begin
        cur_word = pending_words.pop_front();
        stall_pct <= cur_word.sink_stall;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cur_word.op;
        s_axis_tlast <= cur_word.klast;
        s_axis_tdata <= {5'd0, cur_word.off, cur_word.idx, cur_word.kb};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stall at random, compare each taken word with the oldest answer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t e;
    answer_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= stall_pct;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.hit    = m_axis_tdata[5:3];
        got.count  = m_axis_tdata[9:6];
        got.rbyte  = m_axis_tdata[17:10];
        got.rlen   = m_axis_tdata[25:18];
        answers_seen++;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word %h at cycle %0d", m_axis_tdata, cycles);
        end else begin
          e = expected_answers.pop_front();
          status_seen[e.status]++;
          if (got != e) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at cycle %0d: exp st=%0d hit=%0d cnt=%0d byte=%h ",
                        "len=%0d, got st=%0d hit=%0d cnt=%0d byte=%h len=%0d"},
                       cycles, e.status, e.hit, e.count, e.rbyte, e.rlen,
                       got.status, got.hit, got.count, got.rbyte, got.rlen);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      order[s] = s;
      slot_len[s] = 0;
    end
    total = 0;
    key_len = 0;
    build_stimulus();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !s_axis_tvalid);
    wait (expected_answers.size() == 0);
    repeat (50) @(posedge clk);
    $display("%0d words sent, %0d results checked (reads %0d, moved %0d, inserted %0d,",
             words_sent, answers_seen, reads_seen, status_seen[ST_MOVED] - reads_seen,
             status_seen[ST_INSERTED]);
    $display("evicted %0d, removed %0d, not found %0d, rejected %0d), %0d mismatches",
             status_seen[ST_EVICTED], status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND],
             status_seen[ST_REJECTED], mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
